// File: hdl/xor_distance_shortlist_unit_assert.svh
// ----------------------------------------------------------------------------
// xor_distance_shortlist_unit_assert
// assertion macros for the shortlist unit, sampled on clk outside reset
// ----------------------------------------------------------------------------
`ifndef XOR_DISTANCE_SHORTLIST_UNIT_ASSERT_SVH
`define XOR_DISTANCE_SHORTLIST_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define XDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define XDS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hdl/xds_pkg.sv
// ----------------------------------------------------------------------------
// xds_pkg
// types and constants shared by the xor distance shortlist unit
// ----------------------------------------------------------------------------
package xds_pkg;

  localparam int CLOSEST_COUNT = 20;
  localparam int CAPACITY      = 2 * CLOSEST_COUNT;
  localparam int ID_BITS       = 64;
  localparam int TAG_BITS      = 16;
  localparam int IDX_BITS      = $clog2(CAPACITY + 1);
  localparam int CFG_IDX_BITS  = 8;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_PICK   = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] KIND_PICKED  = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_READOUT = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_ID = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SELF_ID   = 8'd1;

  typedef struct packed {
    logic [1:0]          mode;
    logic [ID_BITS-1:0]  contact_id;
    logic [TAG_BITS-1:0] contact_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [ID_BITS-1:0]  out_id;
    logic [TAG_BITS-1:0] out_tag;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [TAG_BITS-1:0] tag;
    logic                queried;
  } entry_t;

endpackage

// File: hdl/xor_distance_shortlist_unit.sv
// ----------------------------------------------------------------------------
// xor_distance_shortlist_unit
// lookup shortlist kept sorted by xor distance in one entry memory
// ----------------------------------------------------------------------------
// insert reads and compares each stored entry, shifts the farther entries
//   down one slot and writes the new contact; pick reads entries until an
//   unqueried one and marks it queried; readout reads and sends each listed entry
// input: a new word is taken only in idle, once the entry memory walk of the last one is done
// reset: count, state and output valid clear; entry memory is not cleared
module xor_distance_shortlist_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  xds_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output xds_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [xds_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);
  import xds_pkg::*;

  `include "xor_distance_shortlist_unit_assert.svh"

  typedef enum logic [3:0] {
    IDLE, INS_RD, INS_CHK, SH_RD, SH_WR, INS_WR, PK_RD, PK_CHK, RO_RD, RO_OUT
  } state_t;

  // entry memory: one write port, one registered read port
  entry_t mem [CAPACITY];
  entry_t rdata;

  logic                mem_we;
  logic [IDX_BITS-1:0] mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  logic [IDX_BITS-1:0] mem_raddr;

  state_t              state;
  logic [IDX_BITS-1:0] count;
  logic [IDX_BITS-1:0] idx;      // scan index
  logic [IDX_BITS-1:0] pos;      // insert position
  logic                found;
  logic [ID_BITS-1:0]  target_id;
  logic [ID_BITS-1:0]  self_id;
  logic [ID_BITS-1:0]  cid;
  logic [TAG_BITS-1:0] ctag;
  logic [ID_BITS-1:0]  cdist;

  logic                in_acc;
  logic                out_free;
  logic                emit;
  logic [IDX_BITS-1:0] lim;
  logic [IDX_BITS-1:0] idx_inc;
  logic [IDX_BITS-1:0] pos_now;
  logic [IDX_BITS-1:0] shift_end;
  logic [IDX_BITS-1:0] cap_last;

  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cap_last  = IDX_BITS'(CAPACITY - 1);
  assign lim       = (count < IDX_BITS'(CLOSEST_COUNT)) ? count : IDX_BITS'(CLOSEST_COUNT);
  assign idx_inc   = idx + 1'b1;
  // first entry farther than the new contact fixes the slot
  assign pos_now   = (!found && ((rdata.id ^ target_id) > cdist)) ? idx : pos;
  assign shift_end = (count < IDX_BITS'(CAPACITY)) ? count : cap_last;
  // a result word is loaded this cycle: pick done, pick hit or readout word
  assign emit      = out_free && ((state == PK_RD && idx >= lim) ||
                                  (state == PK_CHK && !rdata.queried) ||
                                  (state == RO_OUT));

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = rdata;
    mem_re    = 1'b0;
    mem_raddr = idx;
    unique case (state)
      INS_RD, PK_RD, RO_RD: begin
        mem_re = (state != PK_RD) || (idx < lim);
      end
      SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx - 1'b1;
      end
      SH_WR: begin
        mem_we = 1'b1;
      end
      INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        mem_wdata = '{id: cid, tag: ctag, queried: 1'b0};
      end
      PK_CHK: begin
        // mark the picked entry as queried
        mem_we            = !rdata.queried && out_free;
        mem_wdata.queried = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[$clog2(CAPACITY)-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr[$clog2(CAPACITY)-1:0]];
    end
  end

  // control and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      target_id <= '0;
      self_id   <= '0;
      idx       <= '0;
      pos       <= '0;
      found     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TARGET_ID) begin
          target_id <= cfg_data[ID_BITS-1:0];
        end else if (cfg_index == REG_SELF_ID) begin
          self_id <= cfg_data[ID_BITS-1:0];
        end
      end
      // output word stays until taken, a new one loads when the slot is free
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            cid   <= in_data.contact_id;
            ctag  <= in_data.contact_tag;
            cdist <= in_data.contact_id ^ target_id;
            idx   <= '0;
            pos   <= count;
            found <= 1'b0;
            unique case (in_data.mode)
              MODE_START: count <= '0;
              MODE_INSERT: begin
                if (in_data.contact_id != self_id) begin
                  state <= (count == '0) ? INS_WR : INS_RD;
                end
              end
              MODE_PICK: state <= PK_RD;
              MODE_READ: begin
                if (lim != '0) begin
                  state <= RO_RD;
                end
              end
            endcase
          end
        end
        INS_RD: state <= INS_CHK;
        INS_CHK: begin
          pos   <= pos_now;
          found <= found || (pos_now == idx);
          if (rdata.id == cid) begin
            state <= IDLE;                 // duplicate, drop it
          end else if (idx_inc < count) begin
            idx   <= idx_inc;
            state <= INS_RD;
          end else if (pos_now >= IDX_BITS'(CAPACITY)) begin
            state <= IDLE;                 // farther than a full list
          end else begin
            idx   <= shift_end;
            state <= (shift_end > pos_now) ? SH_RD : INS_WR;
          end
        end
        SH_RD: state <= SH_WR;
        SH_WR: begin
          idx   <= idx - 1'b1;
          state <= ((idx - 1'b1) > pos) ? SH_RD : INS_WR;
        end
        INS_WR: begin
          if (count < IDX_BITS'(CAPACITY)) begin
            count <= count + 1'b1;
          end
          state <= IDLE;
        end
        PK_RD: begin
          if (idx >= lim) begin
            if (out_free) begin
              out_data  <= '{kind: KIND_DONE, out_id: '0, out_tag: '0, last: 1'b1};
              state     <= IDLE;
            end
          end else begin
            state <= PK_CHK;
          end
        end
        PK_CHK: begin
          if (rdata.queried) begin
            idx   <= idx_inc;
            state <= PK_RD;
          end else if (out_free) begin
            out_data  <= '{kind: KIND_PICKED, out_id: rdata.id, out_tag: rdata.tag,
                           last: 1'b1};
            state     <= IDLE;
          end
        end
        RO_RD: state <= RO_OUT;
        RO_OUT: begin
          if (out_free) begin
            out_data  <= '{kind: KIND_READOUT, out_id: rdata.id, out_tag: rdata.tag,
                           last: (idx_inc == lim)};
            idx       <= idx_inc;
            state     <= (idx_inc == lim) ? IDLE : RO_RD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `XDS_ASSERT(a_count_cap, count <= IDX_BITS'(CAPACITY), "entry count over capacity")
  `XDS_NEVER(a_idle_no_write, state == IDLE && mem_we, "memory write while idle")
  `XDS_ASSERT(a_count_hold, (state != INS_WR && !in_acc) |=> count == $past(count), "count moved")
  `XDS_ASSERT(a_emit_free, (state == RO_OUT && !out_free) |=> state == RO_OUT, "readout ran ahead")

endmodule
